[rtl/hashed_key_counter_core_defines.svh]
// Assertion macros used by the port checker file.
`ifndef HASHED_KEY_COUNTER_CORE_DEFINES_SVH
`define HASHED_KEY_COUNTER_CORE_DEFINES_SVH
// Asserts that a property holds on every clock edge outside reset.
`define HKC_ASSERT(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("assertion failed");
// Asserts a property that is checked through reset as well.
`define HKC_ASSERT_ALWAYS(label, clk_sig, prop) \
  label: assert property (@(posedge clk_sig) (prop)) else $error("assertion failed");
`endif

[rtl/hkc_pkg.sv]
// Package with the types, constants and hash mixing constants of the key counter.
`timescale 1ns / 1ps
package hkc_pkg;
  localparam int LOG2_SLOTS = 12;
  localparam int SLOTS = 1 << LOG2_SLOTS;
  localparam int OCC_W = LOG2_SLOTS + 1;
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_GET = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] key;
    logic [31:0] delta;
  } req_t;

  typedef struct packed {
    logic [31:0] count;
    logic        found;
    logic        refused;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_M1A, S_M1B, S_M1C, S_H1M, S_M2A, S_M2B, S_M2C, S_H2M, S_H3,
    S_READ, S_WAIT, S_CHECK, S_DONE
  } state_t;
endpackage

[rtl/hashed_key_counter_core.sv]
// Top level of the hashed key counter with its key and count memories.
// Flow: after start, the key is mixed by two 64-bit multiplies with xor-shifts, then slots are
// probed linearly from the hashed position; each hash multiply takes three 32-bit products.
// Requests are taken one at a time; a new one is accepted only once busy is low again.
// Reset clears the control state and occupancy; a clearing pass over every slot then
// zeroes the count memory while busy stays high. The receiver cannot stall the result.
`timescale 1ns / 1ps
module hashed_key_counter_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  hkc_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output hkc_pkg::rsp_t rsp
);
  import hkc_pkg::*;

  logic [63:0] key_mem [SLOTS];
  logic [31:0] cnt_mem [SLOTS];

  state_t state, state_next;
  req_t cur;
  logic [63:0] z, z_next;
  logic [63:0] acc, acc_next;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [LOG2_SLOTS-1:0] pos, pos_next;
  logic [LOG2_SLOTS:0] steps, steps_next;
  logic [OCC_W-1:0] occupied, occupied_next;
  logic [63:0] rd_key;
  logic [31:0] rd_cnt;
  logic we_key, we_cnt;
  logic [31:0] wr_cnt;
  logic [LOG2_SLOTS-1:0] wr_addr;
  rsp_t rsp_next;
  logic done_next;
  logic [32:0] sum;

  always_ff @(posedge clk) begin
    if (we_key) key_mem[wr_addr] <= cur.key;
    if (we_cnt) cnt_mem[wr_addr] <= wr_cnt;
    rd_key <= key_mem[pos];
    rd_cnt <= cnt_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pos <= '0;
      occupied <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      pos <= pos_next;
      occupied <= occupied_next;
      done <= done_next;
    end
    z <= z_next;
    acc <= acc_next;
    steps <= steps_next;
    rsp <= rsp_next;
    if (start && !busy) cur <= req;
  end

  assign busy = (state != S_IDLE);
  assign sum = {1'b0, rd_cnt} + {1'b0, cur.delta};
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_next = state;
    z_next = z;
    acc_next = acc;
    mul_a = z[31:0];
    mul_b = MIX_C1[31:0];
    pos_next = pos;
    steps_next = steps;
    occupied_next = occupied;
    we_key = 1'b0;
    we_cnt = 1'b0;
    wr_cnt = '0;
    wr_addr = pos;
    rsp_next = rsp;
    done_next = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we_cnt = 1'b1;
        pos_next = pos + 1'b1;
        if (pos == LOG2_SLOTS'(SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          z_next = req.key ^ (req.key >> 30);
          state_next = S_M1A;
        end
      end
      S_M1A: begin
        mul_a = z[31:0];
        mul_b = MIX_C1[31:0];
        acc_next = mul_p;
        state_next = S_M1B;
      end
      S_M1B: begin
        mul_a = z[63:32];
        mul_b = MIX_C1[31:0];
        acc_next = {acc[63:32] + mul_p[31:0], acc[31:0]};
        state_next = S_M1C;
      end
      S_M1C: begin
        mul_a = z[31:0];
        mul_b = MIX_C1[63:32];
        z_next = {acc[63:32] + mul_p[31:0], acc[31:0]};
        state_next = S_H1M;
      end
      S_H1M: begin
        z_next = z ^ (z >> 27);
        state_next = S_M2A;
      end
      S_M2A: begin
        mul_a = z[31:0];
        mul_b = MIX_C2[31:0];
        acc_next = mul_p;
        state_next = S_M2B;
      end
      S_M2B: begin
        mul_a = z[63:32];
        mul_b = MIX_C2[31:0];
        acc_next = {acc[63:32] + mul_p[31:0], acc[31:0]};
        state_next = S_M2C;
      end
      S_M2C: begin
        mul_a = z[31:0];
        mul_b = MIX_C2[63:32];
        z_next = {acc[63:32] + mul_p[31:0], acc[31:0]};
        state_next = S_H2M;
      end
      S_H2M: begin
        z_next = z ^ (z >> 31);
        state_next = S_H3;
      end
      S_H3: begin
        pos_next = z[LOG2_SLOTS-1:0];
        steps_next = '0;
        state_next = S_READ;
      end
      S_READ: state_next = S_WAIT;
      S_WAIT: state_next = S_CHECK;
      S_CHECK: begin
        done_next = 1'b1;
        state_next = S_DONE;
        if (rd_cnt == 32'd0 || steps == (LOG2_SLOTS+1)'(SLOTS)) begin
          rsp_next = '{count: 32'd0, found: 1'b0, refused: 1'b0};
          if (cur.action == ACT_ADD && cur.delta != 32'd0) begin
            if (rd_cnt != 32'd0 || steps == (LOG2_SLOTS+1)'(SLOTS) ||
                occupied >= OCC_W'(SLOTS / 2)) begin
              rsp_next.refused = 1'b1;
            end else begin
              we_key = 1'b1;
              we_cnt = 1'b1;
              wr_cnt = cur.delta;
              occupied_next = occupied + 1'b1;
              rsp_next.count = cur.delta;
            end
          end
        end else if (rd_key == cur.key) begin
          rsp_next = '{count: rd_cnt, found: 1'b1, refused: 1'b0};
          if (cur.action == ACT_ADD && cur.delta != 32'd0) begin
            wr_cnt = sum[32] ? 32'hffff_ffff : sum[31:0];
            we_cnt = 1'b1;
            rsp_next.count = wr_cnt;
          end
        end else begin
          done_next = 1'b0;
          pos_next = pos + 1'b1;
          steps_next = steps + 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

[rtl/hkc_checker.sv]
// Port checker for the hashed key counter, bound to the top level.
`timescale 1ns / 1ps
`include "hashed_key_counter_core_defines.svh"
module hkc_port_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input hkc_pkg::rsp_t rsp
);
  import hkc_pkg::*;
  `HKC_ASSERT(a_start_busy, clk, rst, (start && !busy) |=> busy)
  `HKC_ASSERT(a_done_busy, clk, rst, done |-> busy)
  `HKC_ASSERT(a_done_single, clk, rst, done |=> !done)
  `HKC_ASSERT(a_refuse_zero, clk, rst, (done && rsp.refused) |-> (rsp.count == '0 && !rsp.found))
  `HKC_ASSERT_ALWAYS(a_reset_busy, clk, $past(rst) |-> busy)
endmodule

bind hashed_key_counter_core hkc_port_checker u_hkc_checker (.*);
